### rtl/gbbs_pkg.sv
`default_nettype none
package gbbs_pkg;

    localparam int FRAC_BITS = 40;
    localparam int EPS_SHIFT = 48;
    localparam int GOLD_SHIFT = 32;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] EPS_Q48 = 64'sd28147;
    localparam logic signed [63:0] GOLD_Q32 = 64'sd1640531527;
    localparam longint TOL_RAW = 64'sd2814750 >>> (48 - FRAC_BITS);
    localparam logic signed [63:0] TOL_C = (TOL_RAW < 1) ? 64'sd1 : 64'(TOL_RAW);

    localparam logic [10:0] GRID_MIN = 11'd2;
    localparam logic [10:0] GRID_MAX = 11'd1024;

    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_UPPER = 3'd1;
    localparam logic [2:0] REG_GRID = 3'd2;
    localparam logic [2:0] REG_MODE = 3'd3;
    localparam logic [2:0] REG_TARGET = 3'd4;
    localparam logic [2:0] REG_ITER = 3'd5;
    localparam logic [2:0] REG_RETRY = 3'd6;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;

    localparam logic ACT_START = 1'b0;
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GRID,
        PH_FIRST,
        PH_BRENT
    } phase_t;

    typedef enum logic [1:0] {
        SH_EPS,
        SH_FRAC,
        SH_GOLD
    } shift_t;

    typedef enum logic [5:0] {
        OP_NONE, OP_START, OP_GDIV, OP_GEMIT, OP_OBJ, OP_GBEST, OP_GNEXT, OP_INITV,
        OP_UPDATE, OP_SEARCH, OP_RETRY, OP_FIN0, OP_FIN1, OP_MID, OP_TOL, OP_T2,
        OP_MUL_R, OP_SET_R, OP_MUL_Q, OP_SET_Q, OP_MUL_PA, OP_SET_PA, OP_MUL_PB,
        OP_SET_P, OP_PQ, OP_MUL_QR, OP_SET_QR, OP_MUL_QA, OP_SET_QA, OP_MUL_QB,
        OP_SET_QB, OP_PDIV, OP_SET_D, OP_ADJ, OP_GOLD, OP_MUL_G, OP_SET_DG, OP_STEP
    } dp_op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_START, S_GDIV, S_GDIV_W, S_GEMIT, S_OBJ, S_GBEST, S_GNEXT, S_INITV,
        S_UPDATE, S_HEAD, S_RETRY, S_FIN0, S_FIN1, S_TOL_W, S_T2, S_CONV, S_R, S_R_W,
        S_Q, S_Q_W, S_PA, S_PA_W, S_PB, S_PB_W, S_PQ, S_QR, S_QR_W, S_QA, S_QA_W,
        S_QB, S_QB_W, S_PCHK, S_PDIV_W, S_ADJ, S_GOLD, S_GMUL, S_GMUL_W, S_STEP
    } ctrl_state_t;

    typedef struct packed {
        phase_t phase;
        logic   grid_more;
        logic   iter_done;
        logic   retry_over;
        logic   conv_ok;
        logic   para_ok;
        logic   step_ok;
        logic   mul_done;
        logic   div_done;
        logic   out_busy;
    } dp_stat_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SMIN : SMAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SMIN : SMAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == SMIN) ? SMAX : -a;
    endfunction

    function automatic logic signed [63:0] sabs(input logic signed [63:0] a);
        return a[63] ? sat_neg(a) : a;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg,
                                                    input logic ovf);
        if (neg)
            return (ovf || m > 64'h8000_0000_0000_0000) ? SMIN : (64'd0 - m);
        return (ovf || m[63]) ? SMAX : m;
    endfunction

    function automatic logic signed [63:0] midpoint(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s[64:1];
    endfunction

    function automatic logic signed [63:0] half_tz(input logic signed [63:0] v);
        logic signed [64:0] t;
        t = {v[63], v} + {64'd0, v[63]};
        return t[64:1];
    endfunction

endpackage
`default_nettype wire

### rtl/gbbs_mul.sv
`default_nettype none
module gbbs_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [63:0]     a,
    input  logic signed [63:0]     b,
    input  gbbs_pkg::shift_t       sh,
    output logic signed [63:0]     res,
    output logic                   done
);
    import gbbs_pkg::*;

    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    shift_t       sh_reg;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic signed [63:0] res_reg, res_next;
    logic [31:0]  a_part, b_part;
    logic [63:0]  prod;
    logic [127:0] prod_sh;
    logic [127:0] shifted;

    assign a_part = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_part = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign prod = a_part * b_part;

    always_comb
    begin
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    prod_sh = {64'd0, prod};
            2'd1:    prod_sh = {32'd0, prod, 32'd0};
            default: prod_sh = {prod, 64'd0};
        endcase
        case (sh_reg)
            SH_EPS:  shifted = acc_reg >> EPS_SHIFT;
            SH_GOLD: shifted = acc_reg >> GOLD_SHIFT;
            default: shifted = acc_reg >> FRAC_BITS;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        fin_next = 1'b0;
        done_next = 1'b0;
        res_next = res_reg;
        if (start)
        begin
            acc_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + prod_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            res_next = from_mag(shifted[63:0], neg_reg, |shifted[127:64]);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg <= fin_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg <= mag(a);
            ub_reg <= mag(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg <= sh;
        end
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign res = res_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/gbbs_div.sv
`default_nettype none
module gbbs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [127:0]       dividend,
    input  logic [63:0]        divisor,
    input  logic               neg,
    output logic signed [63:0] res,
    output logic               done
);
    import gbbs_pkg::*;

    logic [127:0] dvd_reg, dvd_next;
    logic [63:0]  dsr_reg;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  quo_reg, quo_next;
    logic         ovf_reg, ovf_next;
    logic         neg_reg;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic signed [63:0] res_reg, res_next;
    logic [64:0]  rem_sh;
    logic [64:0]  rem_sub;
    logic         ge;

    assign rem_sh = {rem_reg, dvd_reg[127]};
    assign ge = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        fin_next = 1'b0;
        done_next = 1'b0;
        res_next = res_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[126:0], 1'b0};
            rem_next = ge ? rem_sub[63:0] : rem_sh[63:0];
            ovf_next = ovf_reg | quo_reg[63];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            res_next = from_mag(quo_reg, neg_reg, ovf_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg <= fin_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            neg_reg <= neg;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
    end

    assign res = res_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/gbbs_ctrl.sv
`default_nettype none
module gbbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                action,
    input  gbbs_pkg::dp_stat_t  st,
    output gbbs_pkg::dp_op_t    op,
    output logic                ready
);
    import gbbs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (action == ACT_START)
                        state_next = S_START;
                    else if (st.phase != PH_IDLE)
                        state_next = S_OBJ;
                end
            S_START:  state_next = S_GDIV;
            S_GDIV:   state_next = S_GDIV_W;
            S_GDIV_W: if (st.div_done) state_next = S_GEMIT;
            S_GEMIT:  if (!st.out_busy) state_next = S_IDLE;
            S_OBJ:
                unique case (st.phase)
                    PH_GRID:  state_next = S_GBEST;
                    PH_FIRST: state_next = S_INITV;
                    PH_BRENT: state_next = S_UPDATE;
                    default:  state_next = S_IDLE;
                endcase
            S_GBEST:  state_next = S_GNEXT;
            S_GNEXT:  if (!st.out_busy) state_next = S_IDLE;
            S_INITV:  state_next = S_HEAD;
            S_UPDATE: state_next = S_HEAD;
            S_HEAD:   state_next = st.iter_done ? S_RETRY : S_TOL_W;
            S_RETRY:  state_next = st.retry_over ? S_FIN0 : S_GDIV;
            S_FIN0:   if (!st.out_busy) state_next = S_IDLE;
            S_FIN1:   if (!st.out_busy) state_next = S_IDLE;
            S_TOL_W:  if (st.mul_done) state_next = S_T2;
            S_T2:     state_next = S_CONV;
            S_CONV:
                if (st.conv_ok)
                    state_next = S_FIN1;
                else if (st.para_ok)
                    state_next = S_R;
                else
                    state_next = S_GOLD;
            S_R:      state_next = S_R_W;
            S_R_W:    if (st.mul_done) state_next = S_Q;
            S_Q:      state_next = S_Q_W;
            S_Q_W:    if (st.mul_done) state_next = S_PA;
            S_PA:     state_next = S_PA_W;
            S_PA_W:   if (st.mul_done) state_next = S_PB;
            S_PB:     state_next = S_PB_W;
            S_PB_W:   if (st.mul_done) state_next = S_PQ;
            S_PQ:     state_next = S_QR;
            S_QR:     state_next = S_QR_W;
            S_QR_W:   if (st.mul_done) state_next = S_QA;
            S_QA:     state_next = S_QA_W;
            S_QA_W:   if (st.mul_done) state_next = S_QB;
            S_QB:     state_next = S_QB_W;
            S_QB_W:   if (st.mul_done) state_next = S_PCHK;
            S_PCHK:   state_next = st.step_ok ? S_PDIV_W : S_GOLD;
            S_PDIV_W: if (st.div_done) state_next = S_ADJ;
            S_ADJ:    state_next = S_STEP;
            S_GOLD:   state_next = S_GMUL;
            S_GMUL:   state_next = S_GMUL_W;
            S_GMUL_W: if (st.mul_done) state_next = S_STEP;
            S_STEP:   if (!st.out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            S_START:  op = OP_START;
            S_GDIV:   op = OP_GDIV;
            S_GEMIT:  if (!st.out_busy) op = OP_GEMIT;
            S_OBJ:    op = OP_OBJ;
            S_GBEST:  op = OP_GBEST;
            S_GNEXT:  if (!st.out_busy) op = OP_GNEXT;
            S_INITV:  op = OP_INITV;
            S_UPDATE: op = OP_UPDATE;
            S_HEAD:   op = st.iter_done ? OP_SEARCH : OP_MID;
            S_RETRY:  if (!st.retry_over) op = OP_RETRY;
            S_FIN0:   if (!st.out_busy) op = OP_FIN0;
            S_FIN1:   if (!st.out_busy) op = OP_FIN1;
            S_TOL_W:  if (st.mul_done) op = OP_TOL;
            S_T2:     op = OP_T2;
            S_R:      op = OP_MUL_R;
            S_R_W:    if (st.mul_done) op = OP_SET_R;
            S_Q:      op = OP_MUL_Q;
            S_Q_W:    if (st.mul_done) op = OP_SET_Q;
            S_PA:     op = OP_MUL_PA;
            S_PA_W:   if (st.mul_done) op = OP_SET_PA;
            S_PB:     op = OP_MUL_PB;
            S_PB_W:   if (st.mul_done) op = OP_SET_P;
            S_PQ:     op = OP_PQ;
            S_QR:     op = OP_MUL_QR;
            S_QR_W:   if (st.mul_done) op = OP_SET_QR;
            S_QA:     op = OP_MUL_QA;
            S_QA_W:   if (st.mul_done) op = OP_SET_QA;
            S_QB:     op = OP_MUL_QB;
            S_QB_W:   if (st.mul_done) op = OP_SET_QB;
            S_PCHK:   if (st.step_ok) op = OP_PDIV;
            S_PDIV_W: if (st.div_done) op = OP_SET_D;
            S_ADJ:    op = OP_ADJ;
            S_GOLD:   op = OP_GOLD;
            S_GMUL:   op = OP_MUL_G;
            S_GMUL_W: if (st.mul_done) op = OP_SET_DG;
            S_STEP:   if (!st.out_busy) op = OP_STEP;
            default:  op = OP_NONE;
        endcase
    end

    assign ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == ACT_START) |=> (state_reg == S_START))
        else $error("start transfer did not restart the search");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOL_W && !st.mul_done) |=> (state_reg == S_TOL_W))
        else $error("tolerance wait left before the product arrived");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PCHK && st.step_ok) |=> (state_reg == S_PDIV_W))
        else $error("parabolic step taken without a division");

endmodule
`default_nettype wire

### rtl/gbbs_dp.sv
`default_nettype none
module gbbs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_fire,
    input  logic [63:0]         sample,
    input  gbbs_pkg::dp_op_t    op,
    output gbbs_pkg::dp_stat_t  st,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [127:0]        m_tdata,
    output logic [1:0]          m_tuser
);
    import gbbs_pkg::*;

    logic signed [63:0] lower_reg, upper_reg, target_reg;
    logic [10:0] gpts_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  ilim_reg, rlim_reg;
    logic signed [63:0] sample_reg;

    phase_t phase_reg, phase_next;
    logic [9:0] gidx_reg, gidx_next;
    logic [7:0] iter_reg, iter_next;
    logic [8:0] retry_reg, retry_next;
    logic signed [63:0] gstep_reg, gstep_next, slo_reg, slo_next, shi_reg, shi_next;
    logic signed [63:0] ba_reg, ba_next, bb_reg, bb_next, bpt_reg, bpt_next;
    logic signed [63:0] bval_reg, bval_next;
    logic signed [63:0] x_reg, x_next, w_reg, w_next, v_reg, v_next;
    logic signed [63:0] fx_reg, fx_next, fw_reg, fw_next, fv_reg, fv_next;
    logic signed [63:0] sp_reg, sp_next, sl_reg, sl_next, probe_reg, probe_next;
    logic signed [63:0] y_reg, y_next, m_reg, m_next, tol_reg, tol_next;
    logic signed [63:0] t2_reg, t2_next, hba_reg, hba_next;
    logic signed [63:0] r_reg, r_next, q_reg, q_next, pa_reg, pa_next;
    logic signed [63:0] p_reg, p_next, dq_reg, dq_next, rold_reg, rold_next;
    logic signed [63:0] qr_reg, qr_next, qa_reg, qa_next, qb_reg, qb_next;
    logic signed [63:0] d_reg, d_next, ut_reg, ut_next;
    logic        ov_reg, ov_next, okind_reg, okind_next, oconv_reg, oconv_next;
    logic signed [63:0] opt_reg, opt_next, oobj_reg, oobj_next;

    logic emit, e_kind, e_conv;
    logic signed [63:0] e_pt, e_obj;

    logic [10:0] gcnt;
    logic signed [63:0] lo_c, hi_c, snl_c, snh_c, xm_c, q2_c, adj_c;

    logic mul_start, mul_done, div_start, div_done;
    logic signed [63:0] mul_a, mul_b, mul_res, div_res;
    shift_t mul_sh;
    logic [127:0] div_dvd;
    logic [63:0]  div_dsr;
    logic         div_neg;

    assign gcnt = (gpts_reg < GRID_MIN) ? GRID_MIN :
                  ((gpts_reg > GRID_MAX) ? GRID_MAX : gpts_reg);

    always_comb
    begin
        mul_start = 1'b1;
        mul_a = sabs(x_reg);
        mul_b = EPS_Q48;
        mul_sh = SH_FRAC;
        case (op)
            OP_MID:
            begin
                mul_a = sabs(x_reg);
                mul_b = EPS_Q48;
                mul_sh = SH_EPS;
            end
            OP_MUL_R:
            begin
                mul_a = sat_sub(x_reg, w_reg);
                mul_b = sat_sub(fx_reg, fv_reg);
            end
            OP_MUL_Q:
            begin
                mul_a = sat_sub(x_reg, v_reg);
                mul_b = sat_sub(fx_reg, fw_reg);
            end
            OP_MUL_PA:
            begin
                mul_a = sat_sub(x_reg, v_reg);
                mul_b = q_reg;
            end
            OP_MUL_PB:
            begin
                mul_a = sat_sub(x_reg, w_reg);
                mul_b = r_reg;
            end
            OP_MUL_QR:
            begin
                mul_a = q_reg;
                mul_b = rold_reg;
            end
            OP_MUL_QA:
            begin
                mul_a = q_reg;
                mul_b = sat_sub(ba_reg, x_reg);
            end
            OP_MUL_QB:
            begin
                mul_a = q_reg;
                mul_b = sat_sub(bb_reg, x_reg);
            end
            OP_MUL_G:
            begin
                mul_a = sp_reg;
                mul_b = GOLD_Q32;
                mul_sh = SH_GOLD;
            end
            default: mul_start = 1'b0;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd = {64'd0, sat_sub(shi_reg, slo_reg)};
        div_dsr = {53'd0, gcnt - 11'd1};
        div_neg = 1'b0;
        if (op == OP_GDIV || op == OP_RETRY)
            div_start = 1'b1;
        else if (op == OP_PDIV)
        begin
            div_start = 1'b1;
            div_dvd = {64'd0, mag(p_reg)} << FRAC_BITS;
            div_dsr = mag(q_reg);
            div_neg = p_reg[63] ^ q_reg[63];
        end
    end

    gbbs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .res   (mul_res),
        .done  (mul_done)
    );

    gbbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .neg      (div_neg),
        .res      (div_res),
        .done     (div_done)
    );

    assign lo_c = sat_sub(bpt_reg, gstep_reg);
    assign hi_c = sat_add(bpt_reg, gstep_reg);
    assign snl_c = (lo_c > slo_reg) ? lo_c : slo_reg;
    assign snh_c = (hi_c < shi_reg) ? hi_c : shi_reg;
    assign xm_c = (bpt_reg < snh_c) ? bpt_reg : snh_c;
    assign q2_c = sat_add(dq_reg, dq_reg);
    assign adj_c = sabs(d_reg) >= tol_reg ? d_reg : (d_reg[63] ? sat_neg(tol_reg) : tol_reg);

    always_comb
    begin
        phase_next = phase_reg; gidx_next = gidx_reg; iter_next = iter_reg;
        retry_next = retry_reg; gstep_next = gstep_reg; slo_next = slo_reg;
        shi_next = shi_reg; ba_next = ba_reg; bb_next = bb_reg; bpt_next = bpt_reg;
        bval_next = bval_reg; x_next = x_reg; w_next = w_reg; v_next = v_reg;
        fx_next = fx_reg; fw_next = fw_reg; fv_next = fv_reg; sp_next = sp_reg;
        sl_next = sl_reg; probe_next = probe_reg; y_next = y_reg; m_next = m_reg;
        tol_next = tol_reg; t2_next = t2_reg; hba_next = hba_reg; r_next = r_reg;
        q_next = q_reg; pa_next = pa_reg; p_next = p_reg; dq_next = dq_reg;
        rold_next = rold_reg; qr_next = qr_reg; qa_next = qa_reg; qb_next = qb_reg;
        d_next = d_reg; ut_next = ut_reg;
        emit = 1'b0; e_kind = KIND_REQUEST; e_conv = 1'b0; e_pt = probe_reg; e_obj = '0;
        unique case (op)
            OP_START:
            begin
                slo_next = (lower_reg < upper_reg) ? lower_reg : upper_reg;
                shi_next = (lower_reg < upper_reg) ? upper_reg : lower_reg;
                retry_next = '0;
            end
            OP_GEMIT:
            begin
                gstep_next = div_res;
                gidx_next = '0;
                probe_next = slo_reg;
                phase_next = PH_GRID;
                emit = 1'b1;
                e_pt = slo_reg;
            end
            OP_OBJ:
            begin
                case (mode_reg)
                    MODE_MIN: y_next = sample_reg;
                    MODE_MAX: y_next = sat_neg(sample_reg);
                    default:  y_next = sabs(sat_sub(sample_reg, target_reg));
                endcase
            end
            OP_GBEST:
                if (gidx_reg == '0 || y_reg < bval_reg)
                begin
                    bpt_next = probe_reg;
                    bval_next = y_reg;
                end
            OP_GNEXT:
            begin
                emit = 1'b1;
                if (st.grid_more)
                begin
                    gidx_next = gidx_reg + 10'd1;
                    probe_next = sat_add(probe_reg, gstep_reg);
                    e_pt = sat_add(probe_reg, gstep_reg);
                end
                else
                begin
                    slo_next = snl_c;
                    shi_next = snh_c;
                    x_next = xm_c; w_next = xm_c; v_next = xm_c;
                    sp_next = '0; sl_next = '0;
                    ba_next = snl_c; bb_next = snh_c;
                    iter_next = '0;
                    probe_next = xm_c;
                    phase_next = PH_FIRST;
                    e_pt = xm_c;
                end
            end
            OP_INITV:
            begin
                fx_next = y_reg; fw_next = y_reg; fv_next = y_reg;
            end
            OP_UPDATE:
            begin
                iter_next = iter_reg + 8'd1;
                if (y_reg <= fx_reg)
                begin
                    if (probe_reg < x_reg)
                        bb_next = x_reg;
                    else
                        ba_next = x_reg;
                    v_next = w_reg; fv_next = fw_reg;
                    w_next = x_reg; fw_next = fx_reg;
                    x_next = probe_reg; fx_next = y_reg;
                end
                else
                begin
                    if (probe_reg < x_reg)
                        ba_next = probe_reg;
                    else
                        bb_next = probe_reg;
                    if (y_reg <= fw_reg || w_reg == x_reg)
                    begin
                        v_next = w_reg; fv_next = fw_reg;
                        w_next = probe_reg; fw_next = y_reg;
                    end
                    else if (y_reg <= fv_reg || v_reg == x_reg || v_reg == w_reg)
                    begin
                        v_next = probe_reg; fv_next = y_reg;
                    end
                end
            end
            OP_SEARCH:
            begin
                slo_next = ba_reg;
                shi_next = bb_reg;
            end
            OP_RETRY: retry_next = retry_reg + 9'd1;
            OP_FIN0, OP_FIN1:
            begin
                phase_next = PH_IDLE;
                emit = 1'b1;
                e_kind = KIND_FINAL;
                e_pt = x_reg;
                e_obj = (mode_reg == MODE_MAX) ? sat_neg(fx_reg) : fx_reg;
                e_conv = (op == OP_FIN1);
            end
            OP_MID: m_next = midpoint(ba_reg, bb_reg);
            OP_TOL: tol_next = sat_add(mul_res, TOL_C);
            OP_T2:
            begin
                t2_next = sat_add(tol_reg, tol_reg);
                hba_next = half_tz(sat_sub(bb_reg, ba_reg));
            end
            OP_SET_R:  r_next = mul_res;
            OP_SET_Q:  q_next = mul_res;
            OP_SET_PA: pa_next = mul_res;
            OP_SET_P:
            begin
                p_next = sat_sub(pa_reg, mul_res);
                dq_next = sat_sub(q_reg, r_reg);
            end
            OP_PQ:
            begin
                if (q2_c > 0)
                begin
                    q_next = q2_c;
                    p_next = sat_neg(p_reg);
                end
                else
                    q_next = sat_neg(q2_c);
                rold_next = sp_reg;
                sp_next = sl_reg;
            end
            OP_SET_QR: qr_next = mul_res;
            OP_SET_QA: qa_next = mul_res;
            OP_SET_QB: qb_next = mul_res;
            OP_SET_D:
            begin
                d_next = div_res;
                ut_next = sat_add(x_reg, div_res);
            end
            OP_ADJ:
                if (sat_sub(ut_reg, ba_reg) < t2_reg || sat_sub(bb_reg, ut_reg) < t2_reg)
                    d_next = (m_reg < x_reg) ? sat_neg(tol_reg) : tol_reg;
            OP_GOLD:
                sp_next = (x_reg >= m_reg) ? sat_sub(ba_reg, x_reg) : sat_sub(bb_reg, x_reg);
            OP_SET_DG: d_next = mul_res;
            OP_STEP:
            begin
                sl_next = d_reg;
                probe_next = sat_add(x_reg, adj_c);
                phase_next = PH_BRENT;
                emit = 1'b1;
                e_pt = sat_add(x_reg, adj_c);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st.phase = phase_reg;
        st.grid_more = ({1'b0, gidx_reg} + 11'd1) < gcnt;
        st.iter_done = iter_reg >= ilim_reg;
        st.retry_over = retry_reg > {1'b0, rlim_reg};
        st.conv_ok = sabs(sat_sub(x_reg, m_reg)) <= sat_sub(t2_reg, hba_reg);
        st.para_ok = sabs(sp_reg) > tol_reg;
        st.step_ok = ($unsigned(sabs(p_reg)) < (mag(qr_reg) >> 1)) &&
                     (p_reg > qa_reg) && (p_reg < qb_reg);
        st.mul_done = mul_done;
        st.div_done = div_done;
        st.out_busy = ov_reg & ~m_tready;
    end

    assign ov_next = emit | (ov_reg & ~m_tready);
    assign okind_next = emit ? e_kind : okind_reg;
    assign oconv_next = emit ? e_conv : oconv_reg;
    assign opt_next = emit ? e_pt : opt_reg;
    assign oobj_next = emit ? e_obj : oobj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= 64'sd1 <<< FRAC_BITS;
            gpts_reg <= 11'd100;
            mode_reg <= 2'd2;
            target_reg <= '0;
            ilim_reg <= 8'd100;
            rlim_reg <= 8'd10;
            phase_reg <= PH_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOWER:  lower_reg <= cfg_data;
                    REG_UPPER:  upper_reg <= cfg_data;
                    REG_GRID:   gpts_reg <= cfg_data[10:0];
                    REG_MODE:   mode_reg <= cfg_data[1:0];
                    REG_TARGET: target_reg <= cfg_data;
                    REG_ITER:   ilim_reg <= cfg_data[7:0];
                    REG_RETRY:  rlim_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            phase_reg <= phase_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= sample;
        gidx_reg <= gidx_next; iter_reg <= iter_next; retry_reg <= retry_next;
        gstep_reg <= gstep_next; slo_reg <= slo_next; shi_reg <= shi_next;
        ba_reg <= ba_next; bb_reg <= bb_next; bpt_reg <= bpt_next; bval_reg <= bval_next;
        x_reg <= x_next; w_reg <= w_next; v_reg <= v_next;
        fx_reg <= fx_next; fw_reg <= fw_next; fv_reg <= fv_next;
        sp_reg <= sp_next; sl_reg <= sl_next; probe_reg <= probe_next;
        y_reg <= y_next; m_reg <= m_next; tol_reg <= tol_next;
        t2_reg <= t2_next; hba_reg <= hba_next; r_reg <= r_next; q_reg <= q_next;
        pa_reg <= pa_next; p_reg <= p_next; dq_reg <= dq_next; rold_reg <= rold_next;
        qr_reg <= qr_next; qa_reg <= qa_next; qb_reg <= qb_next;
        d_reg <= d_next; ut_reg <= ut_next;
        okind_reg <= okind_next; oconv_reg <= oconv_next;
        opt_reg <= opt_next; oobj_reg <= oobj_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = {oobj_reg, opt_reg};
    assign m_tuser = {oconv_reg, okind_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(ov_reg && !m_tready))
        else $error("result loaded over an untaken transfer");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, div_done, mul_start}))
        else $error("arithmetic units overlap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_FIN0 || op == OP_FIN1) |=> (phase_reg == PH_IDLE && ov_reg && okind_reg))
        else $error("final answer did not close the search");

endmodule
`default_nettype wire

### rtl/grid_bracket_brent_search.sv
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tdata = sample_value, tuser = action
// m_*       out  tvalid/tready     tdata = point, objective; tuser = result_kind, converged
// cfg_*     in   cfg_we            cfg_index selects register, cfg_data holds value
//
// Start: the grid step comes from the divider, which yields one quotient bit per cycle.
// Grid sample: objective, best-point update, next grid point. Brent sample: a golden
// step takes two products; a parabolic step, eight products and one division.
// One item is worked at a time; s_tready is high only while the sequencer is idle.
// A waiting result holds in the output register; the next item is accepted meanwhile.
// rst_n clears configuration to its defaults and the search to idle.
`default_nettype none
module grid_bracket_brent_search (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] sample_value
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] point, [127:64] objective
    output logic [1:0]   m_tuser,   // [0] result_kind, [1] converged
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import gbbs_pkg::*;

    logic     in_fire;
    dp_op_t   op;
    dp_stat_t st;

    assign in_fire = s_tvalid & s_tready;

    gbbs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .action  (s_tuser),
        .st      (st),
        .op      (op),
        .ready   (s_tready)
    );

    gbbs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .sample    (s_tdata),
        .op        (op),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
